FILE: rtl/nmea_rmc_sentence_parser_macros.svh
// ----------------------------------------------------------------------------
// nmea rmc parser assertion macros
// shared concurrent assertion forms, clocked on clk and disabled in reset
// ----------------------------------------------------------------------------
`ifndef NMEA_RMC_SENTENCE_PARSER_MACROS_SVH
`define NMEA_RMC_SENTENCE_PARSER_MACROS_SVH

// antecedent implies consequent in the same cycle
`define NMEA_RMC_ASSERT_SAME(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |-> (con)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define NMEA_RMC_ASSERT_NEXT(lbl, ant, con, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ant) |=> (con)) \
    else $error(msg);

`endif

FILE: rtl/nmea_rmc_pkg.sv
// ----------------------------------------------------------------------------
// nmea rmc parser package
// character codes, result layout and small decode helpers
// ----------------------------------------------------------------------------
`default_nettype none

package nmea_rmc_pkg;

  localparam logic [7:0] CHR_DOLLAR = 8'h24;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_COMMA  = 8'h2C;
  localparam logic [7:0] CHR_NL     = 8'h0A;
  localparam logic [7:0] CHR_FIX_OK = 8'h41;

  localparam logic [2:0] PREFIX_LEN = 3'd7;

  localparam logic [3:0] FIELD_TIME   = 4'd1;
  localparam logic [3:0] FIELD_STATUS = 4'd2;
  localparam logic [3:0] FIELD_DATE   = 4'd9;
  localparam logic [3:0] FIELD_LAST   = 4'd15;

  localparam logic [7:0] TIME_DIGITS = 8'd6;
  localparam logic [7:0] CHAR_SAT    = 8'd255;

  typedef enum logic [2:0] {
    RC_NOT_RMC   = 3'd0,
    RC_CKS_ERR   = 3'd1,
    RC_PARSE_ERR = 3'd2,
    RC_NO_FIX    = 3'd3,
    RC_VALID_FIX = 3'd4
  } result_code_t;

  // checksum tracker status toward the sentence decoder
  typedef struct packed {
    logic star_seen;
    logic match;
  } cks_status_t;

  // packed result, last field in the lowest bits
  typedef struct packed {
    logic [2:0]   pad;
    logic [15:0]  parse_error_count;
    logic [15:0]  checksum_error_count;
    logic [6:0]   year_two_digit;
    logic [6:0]   month_num;
    logic [6:0]   day_of_month;
    logic [6:0]   seconds;
    logic [6:0]   minutes;
    logic [6:0]   hours;
    result_code_t result_code;
  } result_t;

  // expected character at each position of "$GPRMC,"
  function automatic logic [7:0] rmc_head_char(input logic [2:0] pos);
    logic [7:0] c;
    case (pos)
      3'd0:    c = CHR_DOLLAR;
      3'd1:    c = 8'h47;
      3'd2:    c = 8'h50;
      3'd3:    c = 8'h52;
      3'd4:    c = 8'h4D;
      3'd5:    c = 8'h43;
      3'd6:    c = CHR_COMMA;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  // {ok, value} for an uppercase hex digit
  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [4:0] r;
    if (is_digit(c)) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end else begin
      r = 5'b0;
    end
    return r;
  endfunction

  // two bcd digits to binary
  function automatic logic [6:0] bcd_pair_to_bin(input logic [7:0] bcd);
    logic [6:0] tens;
    logic [6:0] ones;
    tens = {3'b000, bcd[7:4]};
    ones = {3'b000, bcd[3:0]};
    return (tens << 3) + (tens << 1) + ones;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/nmea_rmc_cks.sv
// ----------------------------------------------------------------------------
// nmea rmc checksum tracker
// xor of the bytes between '$' and '*' against the two hex digits after '*'
// ----------------------------------------------------------------------------
`default_nettype none

module nmea_rmc_cks (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic [7:0]                byte_i,
  input  wire logic                      clear_i,
  input  wire logic                      update_i,
  output nmea_rmc_pkg::cks_status_t      status_o
);

  logic [7:0] xor_r, xor_nxt;
  logic       star_r, star_nxt;
  logic [1:0] hex_cnt_r, hex_cnt_nxt;
  logic [7:0] rcv_r, rcv_nxt;
  logic       bad_r, bad_nxt;
  logic [4:0] hex;

  assign hex = nmea_rmc_pkg::hex_nibble(byte_i);

  always_comb begin
    xor_nxt     = xor_r;
    star_nxt    = star_r;
    hex_cnt_nxt = hex_cnt_r;
    rcv_nxt     = rcv_r;
    bad_nxt     = bad_r;
    if (clear_i) begin
      xor_nxt     = 8'h00;
      star_nxt    = 1'b0;
      hex_cnt_nxt = 2'd0;
      rcv_nxt     = 8'h00;
      bad_nxt     = 1'b0;
    end else if (update_i) begin
      if (!star_r) begin
        if (byte_i == nmea_rmc_pkg::CHR_STAR) begin
          star_nxt = 1'b1;
        end else begin
          xor_nxt = xor_r ^ byte_i;
        end
      end else if (hex_cnt_r != 2'd2) begin
        if (!hex[4]) begin
          bad_nxt = 1'b1;
        end else begin
          rcv_nxt = {rcv_r[3:0], hex[3:0]};
        end
        hex_cnt_nxt = hex_cnt_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xor_r     <= 8'h00;
      star_r    <= 1'b0;
      hex_cnt_r <= 2'd0;
      rcv_r     <= 8'h00;
      bad_r     <= 1'b0;
    end else begin
      xor_r     <= xor_nxt;
      star_r    <= star_nxt;
      hex_cnt_r <= hex_cnt_nxt;
      rcv_r     <= rcv_nxt;
      bad_r     <= bad_nxt;
    end
  end

  // {star_seen, match}
  assign status_o = {star_r, (hex_cnt_r == 2'd2) && !bad_r && (rcv_r == xor_r)};

endmodule

`default_nettype wire

FILE: rtl/nmea_rmc_sentence_parser.sv
// ----------------------------------------------------------------------------
// nmea rmc sentence parser
// decodes time, fix status and date from $GPRMC sentences; unless stalled, one byte a cycle
// ----------------------------------------------------------------------------
// usage
//   in_*  : one received ascii byte per request in in_tdata
//   out_* : one result request per newline byte, none for other bytes
//   a sentence opens at the latest '$' and closes at a newline; only
//   "$GPRMC," sentences are decoded, others report code 0 (not rmc)
//   throughput: one byte per cycle while in_tready is high; the parser state
//   is updated in the cycle a byte is taken, so bytes may follow back to back
//   latency: the result of a newline is in the output register and shown
//   on out_tvalid the cycle after the newline is taken
//   stall: a result holds in the output register until taken; while it
//   waits with out_tready low, in_tready is low too, otherwise a new byte
//   is taken in the same cycle the old result leaves
//   reset (rst_n low, synchronous): no sentence open, counters at zero,
//   output register empty
//   MAX_SENTENCE_LEN: a sentence of that many bytes or more from '$' to
//   the newline is a parse error
// ----------------------------------------------------------------------------
`default_nettype none

`include "nmea_rmc_sentence_parser_macros.svh"

module nmea_rmc_sentence_parser #(
  parameter int MAX_SENTENCE_LEN = 128
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // byte_in[7:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // result_code[2:0], hours[9:3], minutes[16:10], seconds[23:17],
  // day_of_month[30:24], month_num[37:31], year_two_digit[44:38],
  // checksum_error_count[60:45], parse_error_count[76:61], zero[79:77]
  output logic [79:0]      out_tdata
);

  localparam int LEN_W = $clog2(MAX_SENTENCE_LEN + 1);
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_SENTENCE_LEN);

  // handshake
  logic in_acc;
  logic out_valid_r;
  nmea_rmc_pkg::result_t out_data_r, result_nxt;

  assign in_tready  = !out_valid_r || out_tready;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // byte classes
  logic is_dollar, is_nl, is_comma, sent_open, upd;
  assign is_dollar = (in_tdata == nmea_rmc_pkg::CHR_DOLLAR);
  assign is_nl     = (in_tdata == nmea_rmc_pkg::CHR_NL);
  assign is_comma  = (in_tdata == nmea_rmc_pkg::CHR_COMMA);

  // sentence state
  logic [2:0]       prefix_pos_r, prefix_pos_nxt;
  logic             matched_r, matched_nxt;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [3:0]       field_r, field_nxt;
  logic [7:0]       fchars_r, fchars_nxt;
  logic [23:0]      time_bcd_r, time_bcd_nxt;   // six bcd digits
  logic             stopped_r, stopped_nxt;
  logic             time_ok_r, time_ok_nxt;
  logic [7:0]       status_r, status_nxt;
  logic [23:0]      date_bcd_r, date_bcd_nxt;
  logic             date_ok_r, date_ok_nxt;
  logic [15:0]      cks_cnt_r, cks_cnt_nxt;
  logic [15:0]      parse_cnt_r, parse_cnt_nxt;

  assign sent_open = (len_r != '0);
  assign upd       = in_acc && sent_open && !is_dollar && !is_nl;

  // checksum side
  nmea_rmc_pkg::cks_status_t cks_status;

  nmea_rmc_cks u_cks (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_i   (in_tdata),
    .clear_i  (in_acc && (is_dollar || is_nl)),
    .update_i (upd),
    .status_o (cks_status)
  );

  // parser next state
  always_comb begin
    prefix_pos_nxt = prefix_pos_r;
    matched_nxt    = matched_r;
    len_nxt        = len_r;
    field_nxt      = field_r;
    fchars_nxt     = fchars_r;
    time_bcd_nxt   = time_bcd_r;
    stopped_nxt    = stopped_r;
    time_ok_nxt    = time_ok_r;
    status_nxt     = status_r;
    date_bcd_nxt   = date_bcd_r;
    date_ok_nxt    = date_ok_r;
    if (in_acc && (is_dollar || is_nl)) begin
      // a new '$' drops the open sentence, a newline closes it
      prefix_pos_nxt = is_dollar ? 3'd1 : 3'd0;
      matched_nxt    = 1'b0;
      len_nxt        = is_dollar ? LEN_W'(1) : '0;
      field_nxt      = 4'd0;
      fchars_nxt     = 8'd0;
      time_bcd_nxt   = 24'd0;
      stopped_nxt    = 1'b0;
      time_ok_nxt    = 1'b0;
      status_nxt     = 8'd0;
      date_bcd_nxt   = 24'd0;
      date_ok_nxt    = 1'b0;
    end else if (upd) begin
      if (len_r != LEN_MAX) begin
        len_nxt = len_r + LEN_W'(1);
      end
      if (!matched_r) begin
        // prefix compare, a miss leaves position zero for the sentence
        if ((prefix_pos_r != 3'd0) && (prefix_pos_r != nmea_rmc_pkg::PREFIX_LEN)) begin
          if (in_tdata == nmea_rmc_pkg::rmc_head_char(prefix_pos_r)) begin
            prefix_pos_nxt = prefix_pos_r + 3'd1;
            if (prefix_pos_nxt == nmea_rmc_pkg::PREFIX_LEN) begin
              matched_nxt = 1'b1;
              field_nxt   = nmea_rmc_pkg::FIELD_TIME;
              fchars_nxt  = 8'd0;
            end
          end else begin
            prefix_pos_nxt = 3'd0;
          end
        end
      end else begin
        // status is the first byte of field 2, even if it is a comma
        if ((field_r == nmea_rmc_pkg::FIELD_STATUS) && (fchars_r == 8'd0)) begin
          status_nxt = in_tdata;
        end
        if (is_comma) begin
          if (field_r == nmea_rmc_pkg::FIELD_TIME) begin
            time_ok_nxt = (fchars_r >= nmea_rmc_pkg::TIME_DIGITS);
          end
          if (field_r == nmea_rmc_pkg::FIELD_DATE) begin
            date_ok_nxt = (fchars_r == nmea_rmc_pkg::TIME_DIGITS);
          end
          if (field_r != nmea_rmc_pkg::FIELD_LAST) begin
            field_nxt = field_r + 4'd1;
          end
          fchars_nxt  = 8'd0;
          stopped_nxt = 1'b0;
        end else begin
          // leading digit run of time or date, kept as bcd
          if (((field_r == nmea_rmc_pkg::FIELD_TIME) ||
               (field_r == nmea_rmc_pkg::FIELD_DATE)) &&
              !stopped_r && (fchars_r < nmea_rmc_pkg::TIME_DIGITS)) begin
            if (nmea_rmc_pkg::is_digit(in_tdata)) begin
              if (field_r == nmea_rmc_pkg::FIELD_TIME) begin
                time_bcd_nxt = {time_bcd_r[19:0], in_tdata[3:0]};
              end else begin
                date_bcd_nxt = {date_bcd_r[19:0], in_tdata[3:0]};
              end
            end else begin
              stopped_nxt = 1'b1;
            end
          end
          if (fchars_r != nmea_rmc_pkg::CHAR_SAT) begin
            fchars_nxt = fchars_r + 8'd1;
          end
        end
      end
    end
  end

  // result decode from the state before the newline
  nmea_rmc_pkg::result_code_t code;
  logic show_time, show_date;

  always_comb begin
    show_time = 1'b0;
    show_date = 1'b0;
    if (!matched_r) begin
      code = nmea_rmc_pkg::RC_NOT_RMC;
    end else if ((len_r >= LEN_MAX) || !cks_status.star_seen) begin
      code = nmea_rmc_pkg::RC_PARSE_ERR;
    end else if (!cks_status.match) begin
      code = nmea_rmc_pkg::RC_CKS_ERR;
    end else if (!time_ok_r) begin
      code = nmea_rmc_pkg::RC_PARSE_ERR;
    end else if (status_r != nmea_rmc_pkg::CHR_FIX_OK) begin
      code      = nmea_rmc_pkg::RC_NO_FIX;
      show_time = 1'b1;
    end else if (!date_ok_r) begin
      code = nmea_rmc_pkg::RC_PARSE_ERR;
    end else begin
      code      = nmea_rmc_pkg::RC_VALID_FIX;
      show_time = 1'b1;
      show_date = 1'b1;
    end
  end

  logic close;
  assign close = in_acc && is_nl;

  // wrapping error counters
  always_comb begin
    cks_cnt_nxt   = cks_cnt_r;
    parse_cnt_nxt = parse_cnt_r;
    if (close && (code == nmea_rmc_pkg::RC_CKS_ERR)) begin
      cks_cnt_nxt = cks_cnt_r + 16'd1;
    end
    if (close && (code == nmea_rmc_pkg::RC_PARSE_ERR)) begin
      parse_cnt_nxt = parse_cnt_r + 16'd1;
    end
  end

  always_comb begin
    result_nxt                      = '0;
    result_nxt.result_code          = code;
    if (show_time) begin
      result_nxt.hours   = nmea_rmc_pkg::bcd_pair_to_bin(time_bcd_r[23:16]);
      result_nxt.minutes = nmea_rmc_pkg::bcd_pair_to_bin(time_bcd_r[15:8]);
      result_nxt.seconds = nmea_rmc_pkg::bcd_pair_to_bin(time_bcd_r[7:0]);
    end
    if (show_date) begin
      result_nxt.day_of_month   = nmea_rmc_pkg::bcd_pair_to_bin(date_bcd_r[23:16]);
      result_nxt.month_num      = nmea_rmc_pkg::bcd_pair_to_bin(date_bcd_r[15:8]);
      result_nxt.year_two_digit = nmea_rmc_pkg::bcd_pair_to_bin(date_bcd_r[7:0]);
    end
    result_nxt.checksum_error_count = cks_cnt_nxt;
    result_nxt.parse_error_count    = parse_cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_pos_r <= 3'd0;
      matched_r    <= 1'b0;
      len_r        <= '0;
      field_r      <= 4'd0;
      fchars_r     <= 8'd0;
      time_bcd_r   <= 24'd0;
      stopped_r    <= 1'b0;
      time_ok_r    <= 1'b0;
      status_r     <= 8'd0;
      date_bcd_r   <= 24'd0;
      date_ok_r    <= 1'b0;
      cks_cnt_r    <= 16'd0;
      parse_cnt_r  <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      prefix_pos_r <= prefix_pos_nxt;
      matched_r    <= matched_nxt;
      len_r        <= len_nxt;
      field_r      <= field_nxt;
      fchars_r     <= fchars_nxt;
      time_bcd_r   <= time_bcd_nxt;
      stopped_r    <= stopped_nxt;
      time_ok_r    <= time_ok_nxt;
      status_r     <= status_nxt;
      date_bcd_r   <= date_bcd_nxt;
      date_ok_r    <= date_ok_nxt;
      cks_cnt_r    <= cks_cnt_nxt;
      parse_cnt_r  <= parse_cnt_nxt;
      if (close) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result payload, loaded only on a newline
  always_ff @(posedge clk) begin
    if (close) begin
      out_data_r <= result_nxt;
    end
  end

  // a waiting result that is not taken blocks the input
  `NMEA_RMC_ASSERT_SAME(a_stall_blocks_input, out_valid_r && !out_tready, !in_tready,
    "input taken while result stalled")

  // a decoded sentence always has an open length count
  `NMEA_RMC_ASSERT_SAME(a_matched_open, matched_r, len_r != '0,
    "prefix matched with no open sentence")

  // checksum error bumps its counter by one
  `NMEA_RMC_ASSERT_NEXT(a_cks_count, close && (code == nmea_rmc_pkg::RC_CKS_ERR),
    cks_cnt_r == $past(cks_cnt_r) + 16'd1, "checksum counter not advanced")

  // date fields stay zero without a valid fix
  `NMEA_RMC_ASSERT_SAME(a_date_only_on_fix,
    out_valid_r && (out_data_r.result_code != nmea_rmc_pkg::RC_VALID_FIX),
    (out_data_r.day_of_month == 7'd0) && (out_data_r.month_num == 7'd0) &&
    (out_data_r.year_two_digit == 7'd0), "date shown without a valid fix")

endmodule

`default_nettype wire

FILE: test/nmea_rmc_sentence_parser_tb.sv
// ----------------------------------------------------------------------------
// nmea rmc sentence parser testbench
// streams directed and random gps sentences, noise and broken frames into the
// parser byte by byte, decodes each byte in a local model of the parser and
// checks every report field by field against the oldest pending report
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nmea_rmc_sentence_parser_tb;

  localparam int MAX_LEN = 128;
  localparam int STIM_BYTES = 1600;

  // how the checksum tail of a shipped sentence is formed
  typedef enum int {
    SUM_GOOD,
    SUM_WRONG,
    SUM_ONE_DIGIT,
    SUM_BAD_DIGIT,
    SUM_MISSING,
    SUM_TRAILING_COMMAS
  } sum_tail_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [79:0] out_tdata;

  nmea_rmc_sentence_parser #(
    .MAX_SENTENCE_LEN(MAX_LEN)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [7:0]            rx_bytes[$];        // bytes waiting to be sent
  nmea_rmc_pkg::result_t pending_reports[$]; // reports the parser still owes us
  int                    stim_total = 1;
  int                    taken_count = 0;
  int                    errors = 0;
  logic                  byte_taken = 1'b0;

  // ---------------------------------------------------------------------------
  // local copy of the sentence decoder
  // ---------------------------------------------------------------------------
  logic [7:0]  rmc_tag [7] = '{8'h24, 8'h47, 8'h50, 8'h52, 8'h4D, 8'h43, 8'h2C};
  int          head_pos;
  bit          head_ok;
  int          sent_len;
  logic [7:0]  run_xor;
  bit          got_star;
  int          sum_digits;
  logic [7:0]  sum_rx;
  bit          sum_bad;
  int          fld;
  int          fld_chars;
  int unsigned time_acc;
  bit          digits_stopped;
  bit          time_ok;
  logic [7:0]  fix_chr;
  int unsigned date_acc;
  bit          date_ok;
  logic [15:0] n_sum_err = '0;
  logic [15:0] n_parse_err = '0;

  function automatic void drop_sentence();
    head_pos = 0;
    head_ok = 0;
    sent_len = 0;
    run_xor = '0;
    got_star = 0;
    sum_digits = 0;
    sum_rx = '0;
    sum_bad = 0;
    fld = 0;
    fld_chars = 0;
    time_acc = 0;
    digits_stopped = 0;
    time_ok = 0;
    fix_chr = '0;
    date_acc = 0;
    date_ok = 0;
  endfunction

  function automatic void decode_byte(logic [7:0] b);
    nmea_rmc_pkg::result_t      r;
    nmea_rmc_pkg::result_code_t code;
    bit                         show_time;
    bit                         show_date;
    if (b == nmea_rmc_pkg::CHR_DOLLAR) begin
      drop_sentence();
      head_pos = 1;
      sent_len = 1;
      return;
    end
    if (b == nmea_rmc_pkg::CHR_NL) begin
      show_time = 0;
      show_date = 0;
      if (!head_ok) begin
        code = nmea_rmc_pkg::RC_NOT_RMC;
      end else if (sent_len >= MAX_LEN || !got_star) begin
        code = nmea_rmc_pkg::RC_PARSE_ERR;
      end else if (sum_digits < 2 || sum_bad || sum_rx != run_xor) begin
        code = nmea_rmc_pkg::RC_CKS_ERR;
      end else if (!time_ok) begin
        code = nmea_rmc_pkg::RC_PARSE_ERR;
      end else if (fix_chr != nmea_rmc_pkg::CHR_FIX_OK) begin
        code = nmea_rmc_pkg::RC_NO_FIX;
        show_time = 1;
      end else if (!date_ok) begin
        code = nmea_rmc_pkg::RC_PARSE_ERR;
      end else begin
        code = nmea_rmc_pkg::RC_VALID_FIX;
        show_time = 1;
        show_date = 1;
      end
      if (code == nmea_rmc_pkg::RC_CKS_ERR) n_sum_err++;
      if (code == nmea_rmc_pkg::RC_PARSE_ERR) n_parse_err++;
      r = '0;
      r.result_code = code;
      if (show_time) begin
        r.hours   = 7'(time_acc / 10000);
        r.minutes = 7'((time_acc / 100) % 100);
        r.seconds = 7'(time_acc % 100);
      end
      if (show_date) begin
        r.day_of_month   = 7'(date_acc / 10000);
        r.month_num      = 7'((date_acc / 100) % 100);
        r.year_two_digit = 7'(date_acc % 100);
      end
      r.checksum_error_count = n_sum_err;
      r.parse_error_count = n_parse_err;
      pending_reports.push_back(r);
      drop_sentence();
      return;
    end
    if (sent_len == 0) return;
    if (sent_len < MAX_LEN) sent_len++;

    // checksum: xor up to the star, then up to two hex digits
    if (!got_star) begin
      if (b == nmea_rmc_pkg::CHR_STAR) got_star = 1;
      else run_xor ^= b;
    end else if (sum_digits < 2) begin
      if (b >= "0" && b <= "9") sum_rx = {sum_rx[3:0], 4'(b - "0")};
      else if (b >= "A" && b <= "F") sum_rx = {sum_rx[3:0], 4'(b - "A" + 10)};
      else sum_bad = 1;
      sum_digits++;
    end

    if (!head_ok) begin
      if (head_pos >= 1 && head_pos < int'(nmea_rmc_pkg::PREFIX_LEN)) begin
        if (b == rmc_tag[head_pos]) begin
          head_pos++;
          if (head_pos == int'(nmea_rmc_pkg::PREFIX_LEN)) begin
            head_ok = 1;
            fld = int'(nmea_rmc_pkg::FIELD_TIME);
            fld_chars = 0;
          end
        end else begin
          head_pos = 0;
        end
      end
    end else begin
      if (fld == int'(nmea_rmc_pkg::FIELD_STATUS) && fld_chars == 0) fix_chr = b;
      if (b == nmea_rmc_pkg::CHR_COMMA) begin
        if (fld == int'(nmea_rmc_pkg::FIELD_TIME)) time_ok = (fld_chars >= 6);
        if (fld == int'(nmea_rmc_pkg::FIELD_DATE)) date_ok = (fld_chars == 6);
        if (fld < int'(nmea_rmc_pkg::FIELD_LAST)) fld++;
        fld_chars = 0;
        digits_stopped = 0;
      end else begin
        if ((fld == int'(nmea_rmc_pkg::FIELD_TIME) ||
             fld == int'(nmea_rmc_pkg::FIELD_DATE)) &&
            !digits_stopped && fld_chars < 6) begin
          if (b >= "0" && b <= "9") begin
            if (fld == int'(nmea_rmc_pkg::FIELD_TIME)) time_acc = time_acc * 10 + (b - "0");
            else date_acc = date_acc * 10 + (b - "0");
          end else begin
            digits_stopped = 1;
          end
        end
        if (fld_chars < 255) fld_chars++;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic void push_raw(string s);
    for (int i = 0; i < s.len(); i++) rx_bytes.push_back(s[i]);
  endfunction

  // '$', body, checksum tail, newline
  function automatic void ship(string body, sum_tail_t tail);
    string      hex_chars;
    string      bad_chars;
    logic [7:0] sum;
    hex_chars = "0123456789ABCDEF";
    bad_chars = "abcdefGXz.,";
    sum = '0;
    for (int i = 0; i < body.len(); i++) sum ^= body[i];
    rx_bytes.push_back(nmea_rmc_pkg::CHR_DOLLAR);
    push_raw(body);
    if (tail == SUM_WRONG) sum ^= 8'(1 << $urandom_range(7));
    if (tail != SUM_MISSING) rx_bytes.push_back(nmea_rmc_pkg::CHR_STAR);
    case (tail)
      SUM_MISSING: ;
      SUM_ONE_DIGIT: rx_bytes.push_back(hex_chars[sum[7:4]]);
      SUM_BAD_DIGIT: begin
        if ($urandom_range(1)) begin
          rx_bytes.push_back(hex_chars[sum[7:4]]);
          rx_bytes.push_back(bad_chars[$urandom_range(bad_chars.len() - 1)]);
        end else begin
          rx_bytes.push_back(bad_chars[$urandom_range(bad_chars.len() - 1)]);
          rx_bytes.push_back(hex_chars[sum[3:0]]);
        end
      end
      default: begin
        rx_bytes.push_back(hex_chars[sum[7:4]]);
        rx_bytes.push_back(hex_chars[sum[3:0]]);
      end
    endcase
    if (tail == SUM_TRAILING_COMMAS) push_raw(",,,");
    rx_bytes.push_back(nmea_rmc_pkg::CHR_NL);
  endfunction

  function automatic string rand_digits(int n);
    string s;
    s = "";
    repeat (n) s = {s, $sformatf("%0d", $urandom_range(9))};
    return s;
  endfunction

  // free text for the position and course fields, now and then a high byte
  function automatic string rand_text(int n);
    string s;
    string pool;
    s = "";
    pool = "0123456789.NSEWAVKMT-";
    repeat (n) begin
      if ($urandom_range(24) == 0) s = {s, $sformatf("%c", 8'($urandom_range(128, 255)))};
      else s = {s, $sformatf("%c", pool[$urandom_range(pool.len() - 1)])};
    end
    return s;
  endfunction

  // rmc body after '$', mostly well formed with the odd defect
  function automatic string rmc_body();
    string s;
    int    k;
    int    nf;
    bit    long_one;
    s = "GPRMC,";
    k = $urandom_range(11);
    if (k == 0) s = {s, rand_digits($urandom_range(5))};
    else if (k == 1) s = {s, rand_digits(2), rand_text(4)};
    else if (k == 2) s = {s, rand_digits(8)};
    else begin
      s = {s, rand_digits(6)};
      if ($urandom_range(1)) s = {s, ".", rand_digits(2)};
    end
    s = {s, ","};
    k = $urandom_range(9);
    if (k < 7) s = {s, "A,"};
    else if (k < 9) s = {s, "V,"};
    else s = {s, rand_text($urandom_range(2)), ","};
    nf = ($urandom_range(11) == 0) ? $urandom_range(3, 8) : 6;
    long_one = ($urandom_range(14) == 0);
    for (int i = 0; i < nf; i++) begin
      if (long_one && i == 0) s = {s, rand_text($urandom_range(100, 130)), ","};
      else s = {s, rand_text($urandom_range(9)), ","};
    end
    k = $urandom_range(11);
    if (k == 0) s = {s, rand_digits(5)};
    else if (k == 1) s = {s, rand_digits(7)};
    else if (k == 2) s = {s, rand_digits(3), rand_text(3)};
    else s = {s, rand_digits(6)};
    // date not closed by a comma now and then
    if ($urandom_range(9) != 0) s = {s, ",", rand_text($urandom_range(5)), ",", rand_text(1)};
    // enough commas to pin the field counter
    if ($urandom_range(9) == 0) s = {s, ",,,,,,,,,,"};
    return s;
  endfunction

  function automatic sum_tail_t rand_tail();
    case ($urandom_range(19))
      0: return SUM_WRONG;
      1: return SUM_ONE_DIGIT;
      2: return SUM_BAD_DIGIT;
      3: return SUM_MISSING;
      4: return SUM_TRAILING_COMMAS;
      default: return SUM_GOOD;
    endcase
  endfunction

  // first third: sender idles 31%, receiver 58%; then swapped; then none
  function automatic int idle_pct(bit receiver);
    if (taken_count < stim_total / 3) return receiver ? 58 : 31;
    if (taken_count < 2 * stim_total / 3) return receiver ? 31 : 58;
    return 0;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  // ---------------------------------------------------------------------------
  // driver, receiver and monitor
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || byte_taken) begin
      if (rx_bytes.size() != 0 && $urandom_range(99) >= idle_pct(1'b0)) begin
        in_tdata  <= rx_bytes.pop_front();
        in_tvalid <= 1'b1;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_tready <= rst_n && ($urandom_range(99) >= idle_pct(1'b1));
  end

  always @(posedge clk) begin : monitor
    nmea_rmc_pkg::result_t got;
    nmea_rmc_pkg::result_t want;
    byte_taken <= rst_n && in_tvalid && in_tready;
    if (rst_n && out_tvalid && out_tready) begin
      got = nmea_rmc_pkg::result_t'(out_tdata);
      if (pending_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report, expected none, actual %h", $time, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        check_field("result_code", want.result_code, got.result_code);
        check_field("hours", want.hours, got.hours);
        check_field("minutes", want.minutes, got.minutes);
        check_field("seconds", want.seconds, got.seconds);
        check_field("day_of_month", want.day_of_month, got.day_of_month);
        check_field("month_num", want.month_num, got.month_num);
        check_field("year_two_digit", want.year_two_digit, got.year_two_digit);
        check_field("checksum_error_count", want.checksum_error_count,
                    got.checksum_error_count);
        check_field("parse_error_count", want.parse_error_count, got.parse_error_count);
        check_field("pad", want.pad, got.pad);
      end
    end
    if (rst_n && in_tvalid && in_tready) begin
      taken_count++;
      decode_byte(in_tdata);
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    string s;
    int    k;
    drop_sentence();

    // directed: lone newline, extremes, ways a sentence can go wrong
    push_raw("\n");
    ship("GPRMC,000000,A,,,,,,,000000,", SUM_GOOD);
    ship("GPRMC,235959.99,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W", SUM_GOOD);
    ship("GPRMC,999999,V,,,,,,,999999,", SUM_GOOD);
    ship("GPGGA,123519,4807.038,N,01131.000,E,1,08,0.9", SUM_GOOD);
    push_raw("$GPR");
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_GOOD);
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_MISSING);
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_ONE_DIGIT);
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_BAD_DIGIT);
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_WRONG);
    ship("GPRMC,12345,A,,,,,,,150624,", SUM_GOOD);
    ship("GPRMC,12a456,A,,,,,,,150624,", SUM_GOOD);
    ship("GPRMC,101010,A,,,,,,,15062,", SUM_GOOD);
    ship("GPRMC,101010,A,,,,,,,150624", SUM_GOOD);
    ship("GPRMC,101010,A,,,,,,,31x299,", SUM_GOOD);
    ship({"GPRMC,101010,A,", rand_text(125), ",,,,,,150624,"}, SUM_GOOD);
    ship("GPRMC,101010,A,,,,,,,150624,", SUM_TRAILING_COMMAS);
    rx_bytes.push_back(8'h00);
    rx_bytes.push_back(8'hFF);
    push_raw("\n");

    // random: mostly well formed rmc, the rest other talkers, noise and cut frames
    while (rx_bytes.size() < STIM_BYTES) begin
      k = $urandom_range(99);
      if (k < 70) begin
        ship(rmc_body(), rand_tail());
      end else if (k < 80) begin
        s = rmc_body();
        s[$urandom_range(5)] = 8'($urandom_range(8'h41, 8'h5A));
        ship(s, rand_tail());
      end else if (k < 90) begin
        repeat ($urandom_range(1, 8)) rx_bytes.push_back(8'($urandom_range(255)));
      end else if (k < 95) begin
        s = rmc_body();
        push_raw({"$", s.substr(0, $urandom_range(s.len() - 1))});
        ship(rmc_body(), rand_tail());
      end else begin
        if ($urandom_range(1)) rx_bytes.push_back(8'($urandom_range(255)));
        rx_bytes.push_back(nmea_rmc_pkg::CHR_NL);
      end
    end
    stim_total = rx_bytes.size();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (rx_bytes.size() != 0 || in_tvalid) @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
